// ----- hw/rtl/lapic_pkg.sv -----
// Shared types, constants and helpers for the local APIC timer and command register slice.
package lapic_pkg;

   localparam int COUNTER_WIDTH = 32;

   typedef logic [COUNTER_WIDTH-1:0] count_type;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   localparam logic [2:0] REG_ENABLE   = 3'd0;
   localparam logic [2:0] REG_TIMER    = 3'd1;
   localparam logic [2:0] REG_INITIAL  = 3'd2;
   localparam logic [2:0] REG_CURRENT  = 3'd3;
   localparam logic [2:0] REG_EOI      = 3'd4;
   localparam logic [2:0] REG_CMD_LOW  = 3'd5;
   localparam logic [2:0] REG_CMD_HIGH = 3'd6;

   localparam int SW_ENABLE_BIT   = 8;
   localparam int TIMER_MASK_BIT  = 16;
   localparam int TIMER_PERIODIC  = 17;
   localparam int DLV_STATUS_BIT  = 12;
   localparam int LEVEL_BIT       = 14;
   localparam int TRIGGER_BIT     = 15;

   localparam logic [2:0] MODE_SMI  = 3'd2;
   localparam logic [2:0] MODE_INIT = 3'd5;

   localparam logic [31:0] ENABLE_RESET = 32'h0000_00FF;
   localparam logic [31:0] TIMER_RESET  = 32'h0001_0000;

   typedef struct packed {
      logic [1:0]  operation;
      logic [2:0]  register_select;
      logic [31:0] write_data;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        timer_fire;
      logic [7:0]  fire_vector;
      logic        eoi_pulse;
      logic        ipi_issued;
      logic        ipi_rejected;
      logic [63:0] ipi_command;
   } rsp_type;

   // Checks a command low word against the SMI, INIT and level rules.
   function automatic logic command_ok(input logic [31:0] low);
      logic [7:0] vec;
      logic [2:0] mode;
      logic       level;
      logic       trig;
      logic       ok;
      vec   = low[7:0];
      mode  = low[10:8];
      level = low[LEVEL_BIT];
      trig  = low[TRIGGER_BIT];
      if (((mode == MODE_SMI) || (mode == MODE_INIT)) && (vec != 8'd0)) begin
         ok = 1'b0;
      end else if (mode != MODE_INIT) begin
         ok = level;
      end else if (!level && !trig) begin
         ok = 1'b0;
      end else begin
         ok = 1'b1;
      end
      return ok;
   endfunction

endpackage

// ----- hw/rtl/lapic_core.sv -----
// Register state and single-pass update logic for ticks, register writes and reads.
module lapic_core
   import lapic_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type req,
   output rsp_type result
);

   logic [31:0] enable_ff, enable_in;
   logic [31:0] timer_ff, timer_in;
   count_type   reload_ff, reload_in;
   count_type   down_ff, down_in;
   logic [31:0] cmd_high_ff, cmd_high_in;
   logic [31:0] cmd_low_ff, cmd_low_in;

   count_type   down_dec;
   logic [31:0] low_clean;

   assign down_dec  = down_ff - count_type'(1);
   assign low_clean = req.write_data & ~(32'd1 << DLV_STATUS_BIT);

   always_comb begin
      enable_in   = enable_ff;
      timer_in    = timer_ff;
      reload_in   = reload_ff;
      down_in     = down_ff;
      cmd_high_in = cmd_high_ff;
      cmd_low_in  = cmd_low_ff;
      result      = '0;

      case (op_type'(req.operation))
         OP_TICK: begin
            cmd_low_in[DLV_STATUS_BIT] = 1'b0;
            if (down_ff != '0) begin
               down_in = down_dec;
               if (down_dec == '0) begin
                  if (enable_ff[SW_ENABLE_BIT] && !timer_ff[TIMER_MASK_BIT]) begin
                     result.timer_fire  = 1'b1;
                     result.fire_vector = timer_ff[7:0];
                  end
                  if (timer_ff[TIMER_PERIODIC]) begin
                     down_in = reload_ff;
                  end
               end
            end
         end
         OP_WRITE: begin
            unique case (req.register_select)
               REG_ENABLE:   enable_in = req.write_data;
               REG_TIMER:    timer_in  = req.write_data;
               REG_INITIAL: begin
                  reload_in = count_type'(req.write_data);
                  down_in   = count_type'(req.write_data);
               end
               REG_EOI:      result.eoi_pulse = 1'b1;
               REG_CMD_LOW: begin
                  if (command_ok(low_clean)) begin
                     cmd_low_in = low_clean | (32'd1 << DLV_STATUS_BIT);
                     result.ipi_issued  = 1'b1;
                     result.ipi_command = {cmd_high_ff,
                                           low_clean | (32'd1 << DLV_STATUS_BIT)};
                  end else begin
                     result.ipi_rejected = 1'b1;
                  end
               end
               REG_CMD_HIGH: cmd_high_in = req.write_data;
               default: ;
            endcase
         end
         OP_READ: begin
            unique case (req.register_select)
               REG_ENABLE:   result.read_data = enable_ff;
               REG_TIMER:    result.read_data = timer_ff;
               REG_INITIAL:  result.read_data = 32'(reload_ff);
               REG_CURRENT:  result.read_data = 32'(down_ff);
               REG_CMD_LOW:  result.read_data = cmd_low_ff;
               REG_CMD_HIGH: result.read_data = cmd_high_ff;
               default:      result.read_data = 32'd0;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= ENABLE_RESET;
         timer_ff    <= TIMER_RESET;
         reload_ff   <= '0;
         down_ff     <= '0;
         cmd_high_ff <= '0;
         cmd_low_ff  <= '0;
      end else if (step) begin
         enable_ff   <= enable_in;
         timer_ff    <= timer_in;
         reload_ff   <= reload_in;
         down_ff     <= down_in;
         cmd_high_ff <= cmd_high_in;
         cmd_low_ff  <= cmd_low_in;
      end
   end

endmodule

// ----- hw/rtl/local_apic_timer_and_ipi_regs_top.sv -----
// Top level of the local APIC timer and command register slice with the result register.
//
//   channel | direction | ports                                   | transaction
//   req     | in        | req_operation, req_register_select,     | tick, write or read
//           |           | req_write_data                          |
//   rsp     | out       | rsp_read_data ... rsp_ipi_command       | one result per request
//
// For each request transaction, the register update and the result are
// computed in the accept cycle and the result is held in the output register.
// A new request is taken every cycle while the output register is empty or being drained.
// Reset is synchronous and restores the core registers and the valid flag; the result register is not reset.
// A stalled result stops further requests until it is taken; no state is lost.
module local_apic_timer_and_ipi_regs_top
   import lapic_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [2:0]  req_register_select,
   input  logic [31:0] req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_data,
   output logic        rsp_timer_fire,
   output logic [7:0]  rsp_fire_vector,
   output logic        rsp_eoi_pulse,
   output logic        rsp_ipi_issued,
   output logic        rsp_ipi_rejected,
   output logic [63:0] rsp_ipi_command
);

   req_type req;
   rsp_type result;
   rsp_type rsp_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    accept;

   assign req       = '{operation: req_operation, register_select: req_register_select,
                        write_data: req_write_data};
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   lapic_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (accept),
      .req    (req),
      .result (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_ff.read_data;
   assign rsp_timer_fire   = rsp_ff.timer_fire;
   assign rsp_fire_vector  = rsp_ff.fire_vector;
   assign rsp_eoi_pulse    = rsp_ff.eoi_pulse;
   assign rsp_ipi_issued   = rsp_ff.ipi_issued;
   assign rsp_ipi_rejected = rsp_ff.ipi_rejected;
   assign rsp_ipi_command  = rsp_ff.ipi_command;

   // A command write is either issued or rejected, never both.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_ipi_issued && rsp_ipi_rejected))
      else $error("command both issued and rejected");

   // An issued command always carries the delivery status bit.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ipi_issued) |-> rsp_ipi_command[DLV_STATUS_BIT])
      else $error("issued command without delivery status");

   // The vector is reported only when the timer fires.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_timer_fire) |-> (rsp_fire_vector == 8'd0))
      else $error("fire vector without timer fire");

   // A result that is taken with no new request leaves the output register empty.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !req_valid) |=> !rsp_valid)
      else $error("result repeated after it was taken");

endmodule
